@@ rtl/core/smau_pkg.sv @@
package smau_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int SLOT_X_W   = SLOT_W + 1;
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    localparam int LEN_MIN    = 2;

    localparam int WLEN_W     = 7;
    localparam int SF_W       = 25;
    localparam int CFG_W      = 25;
    localparam int PRICE_W    = 32;
    localparam int IDX_W      = 32;
    localparam int AVG_W      = 32;
    localparam int SUM_W      = 38;
    localparam int FRAC_W     = 24;

    localparam int SUM_HI_W   = SUM_W - PRICE_W;
    localparam int PROD_LO_W  = PRICE_W + SF_W;
    localparam int PROD_HI_W  = SUM_HI_W + SF_W;
    localparam int PROD_W     = SUM_W + SF_W;
    localparam int SHIFT_W    = PROD_W - FRAC_W;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_LVL_W    = $clog2(Q_DEPTH + 1);

    localparam logic [WLEN_W-1:0] WLEN_RST = WLEN_W'(20);
    localparam logic [SF_W-1:0]   SF_RST   = SF_W'(838861);

    typedef enum logic {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_SCALE_FACTOR  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SUB_NONE,
        SUB_RING,
        SUB_PREV
    } t_sub_sel;

    typedef struct packed {
        logic [PRICE_W-1:0] close_price;
        logic [PRICE_W-1:0] sub_price;
        logic [IDX_W-1:0]   bar_index_res;
        logic               is_revision;
        logic               emit;
    } t_q_entry;

endpackage

@@ rtl/core/smau_if.sv @@
interface smau_in_if;
    import smau_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   bar_index;
    logic [PRICE_W-1:0] close_price;

    modport source (output valid, output bar_index, output close_price, input ready);
    modport sink (input valid, input bar_index, input close_price, output ready);
endinterface

interface smau_out_if;
    import smau_pkg::*;

    logic               valid;
    logic               ready;
    logic [AVG_W-1:0]   average;
    logic [IDX_W-1:0]   bar_index_res;
    logic               is_revision;

    modport source (output valid, output average, output bar_index_res, output is_revision,
                    input ready);
    modport sink (input valid, input average, input bar_index_res, input is_revision,
                  output ready);
endinterface

@@ rtl/core/sliding_window_moving_average_unit.sv @@
// Moving average over the last window_length bar closes.
// Input channel i_item carries bar_index and close_price; a beat whose index
// exceeds the last one opens a new bar, any other beat revises the newest
// close. Output channel o_result carries average, bar_index_res and
// is_revision, one beat per input beat once the window is full.
// Configuration: write i_cfg_wdata into register i_cfg_idx when i_cfg_we is
// high; index 0 is window_length (also restarts the window), index 1 is
// scale_factor. Write only while the unit is idle.
// Throughput: one beat per cycle unless o_result stalls; the running sum closes
// its loop in a single adder each cycle and the ring memory has one write and one read port.
// Pipeline from input accept to output valid: front register, queue write, sum,
// split multiply, add and saturate; the ring read happens at the accept edge.
// Reset clears the window, the queue and the pipeline; the ring needs no
// clearing pass. A stalled receiver backs up the output stages and then the
// four-entry queue; i_item.ready drops when the queue nears full.
module sliding_window_moving_average_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  smau_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [smau_pkg::CFG_W-1:0]      i_cfg_wdata,
    smau_in_if.sink                         i_item,
    smau_out_if.source                      o_result
);
    import smau_pkg::*;

    logic [WLEN_W-1:0]  r_window_length;
    logic [SF_W-1:0]    r_scale_factor;
    logic               restart;

    logic               q_push;
    t_q_entry           q_in;
    logic               q_valid;
    t_q_entry           q_out;
    logic               q_pop;
    logic               q_room;
    logic [Q_LVL_W-1:0] q_level;

    assign restart = i_cfg_we && (i_cfg_idx == CFG_WINDOW_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WLEN_RST;
            r_scale_factor  <= SF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_LENGTH: r_window_length <= i_cfg_wdata[WLEN_W-1:0];
                CFG_SCALE_FACTOR:  r_scale_factor  <= i_cfg_wdata[SF_W-1:0];
                default: ;
            endcase
        end
    end

    smau_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_window_length (r_window_length),
        .i_restart       (restart),
        .i_room          (q_room),
        .i_item          (i_item),
        .o_push          (q_push),
        .o_entry         (q_in)
    );

    smau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_valid (q_valid),
        .o_entry (q_out),
        .i_pop   (q_pop),
        .o_room  (q_room),
        .o_level (q_level)
    );

    smau_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (restart),
        .i_scale_factor (r_scale_factor),
        .i_valid        (q_valid),
        .i_entry        (q_out),
        .o_pop          (q_pop),
        .o_result       (o_result)
    );

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= Q_LVL_W'(Q_DEPTH))
        else $error("queue level beyond depth");

    a_accept_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> q_push)
        else $error("accepted beat did not reach the queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_level < Q_LVL_W'(Q_DEPTH)))
        else $error("push into full queue");
`endif

endmodule

@@ rtl/core/smau_front.sv @@
module smau_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [smau_pkg::WLEN_W-1:0]     i_window_length,
    input  logic                            i_restart,
    input  logic                            i_room,
    smau_in_if.sink                         i_item,
    output logic                            o_push,
    output smau_pkg::t_q_entry              o_entry
);
    import smau_pkg::*;

    localparam int CMP_W = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;

    logic [PRICE_W-1:0] r_ring [MAX_WINDOW];
    logic [PRICE_W-1:0] r_ring_rd;

    logic [LEN_W-1:0]   r_fill, n_fill;
    logic [SLOT_W-1:0]  r_newest, n_newest;
    logic [IDX_W-1:0]   r_last, n_last;
    logic               r_seen;
    logic [PRICE_W-1:0] r_prev_price;

    logic               r_f_v;
    logic [PRICE_W-1:0] r_f_price;
    logic [PRICE_W-1:0] r_f_prev;
    logic [IDX_W-1:0]   r_f_idx;
    logic               r_f_rev;
    logic               r_f_emit;
    t_sub_sel           r_f_sel;

    logic               accept;
    logic [CMP_W-1:0]   wl;
    logic [LEN_W-1:0]   len;
    logic [SLOT_W-1:0]  diff;
    logic [SLOT_W-1:0]  oldest;
    logic [SLOT_W-1:0]  slot_inc;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  wr_slot;
    logic               is_new;
    logic               full;
    t_sub_sel           sel;

    assign i_item.ready = i_room && i_rst_n;
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        wl = CMP_W'(i_window_length);
        if (wl < CMP_W'(LEN_MIN)) begin
            len = LEN_W'(LEN_MIN);
        end else if (wl > CMP_W'(MAX_WINDOW)) begin
            len = LEN_W'(MAX_WINDOW);
        end else begin
            len = LEN_W'(wl);
        end
    end

    always_comb begin
        diff = SLOT_W'(len - LEN_W'(1));
        if (r_newest >= diff) begin
            oldest = r_newest - diff;
        end else begin
            oldest = SLOT_W'(SLOT_X_W'(r_newest) + SLOT_X_W'(MAX_WINDOW) - SLOT_X_W'(diff));
        end
        slot_inc = (r_newest == SLOT_W'(MAX_WINDOW - 1)) ? '0 : r_newest + SLOT_W'(1);
        slot     = r_seen ? slot_inc : r_newest;
        is_new   = !r_seen || (i_item.bar_index > r_last);
        full     = r_fill >= len;
        wr_slot  = is_new ? slot : r_newest;
    end

    always_comb begin
        n_fill   = r_fill;
        n_newest = r_newest;
        n_last   = r_last;
        sel      = SUB_PREV;
        if (is_new) begin
            n_fill   = full ? len : r_fill + LEN_W'(1);
            n_newest = slot;
            n_last   = i_item.bar_index;
            sel      = full ? SUB_RING : SUB_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[wr_slot] <= i_item.close_price;
        end
        r_ring_rd <= r_ring[oldest];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_newest <= '0;
            r_last   <= '0;
            r_seen   <= 1'b0;
            r_f_v    <= 1'b0;
        end else begin
            r_f_v <= accept;
            if (i_restart) begin
                r_fill <= '0;
                r_seen <= 1'b0;
            end else if (accept) begin
                r_fill   <= n_fill;
                r_newest <= n_newest;
                r_last   <= n_last;
                r_seen   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_price <= i_item.close_price;
            r_f_price    <= i_item.close_price;
            r_f_prev     <= r_prev_price;
            r_f_idx      <= n_last;
            r_f_rev      <= !is_new;
            r_f_emit     <= n_fill >= len;
            r_f_sel      <= sel;
        end
    end

    always_comb begin
        o_push                = r_f_v;
        o_entry.close_price   = r_f_price;
        o_entry.bar_index_res = r_f_idx;
        o_entry.is_revision   = r_f_rev;
        o_entry.emit          = r_f_emit;
        case (r_f_sel)
            SUB_RING: o_entry.sub_price = r_ring_rd;
            SUB_PREV: o_entry.sub_price = r_f_prev;
            default:  o_entry.sub_price = '0;
        endcase
    end

endmodule

@@ rtl/core/smau_queue.sv @@
module smau_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  smau_pkg::t_q_entry              i_entry,
    output logic                            o_valid,
    output smau_pkg::t_q_entry              o_entry,
    input  logic                            i_pop,
    output logic                            o_room,
    output logic [smau_pkg::Q_LVL_W-1:0]    o_level
);
    import smau_pkg::*;

    t_q_entry           r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_LVL_W-1:0] r_level, n_level;
    logic               do_pop;

    assign do_pop  = i_pop && (r_level != '0);
    assign o_valid = r_level != '0;
    assign o_entry = r_mem[r_rd];
    assign o_room  = r_level <= Q_LVL_W'(Q_DEPTH - 2);
    assign o_level = r_level;

    always_comb begin
        n_level = r_level;
        if (i_push && !do_pop) begin
            n_level = r_level + Q_LVL_W'(1);
        end else if (!i_push && do_pop) begin
            n_level = r_level - Q_LVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_level <= n_level;
            if (i_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

@@ rtl/core/smau_back.sv @@
module smau_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_restart,
    input  logic [smau_pkg::SF_W-1:0]       i_scale_factor,
    input  logic                            i_valid,
    input  smau_pkg::t_q_entry              i_entry,
    output logic                            o_pop,
    smau_out_if.source                      o_result
);
    import smau_pkg::*;

    logic [SUM_W-1:0]     r_sum, n_sum;

    logic                 r_a_v;
    logic [SUM_W-1:0]     r_a_sum;
    logic [IDX_W-1:0]     r_a_idx;
    logic                 r_a_rev;

    logic                 r_b_v;
    logic [PROD_LO_W-1:0] r_b_plo;
    logic [PROD_HI_W-1:0] r_b_phi;
    logic [IDX_W-1:0]     r_b_idx;
    logic                 r_b_rev;

    logic                 r_o_v;
    logic [AVG_W-1:0]     r_o_avg;
    logic [IDX_W-1:0]     r_o_idx;
    logic                 r_o_rev;

    logic                 o_adv, b_ready, a_ready;
    logic [PROD_W-1:0]    total;
    logic [SHIFT_W-1:0]   shifted;
    logic [AVG_W-1:0]     avg;

    assign o_adv   = !r_o_v || o_result.ready;
    assign b_ready = !r_b_v || o_adv;
    assign a_ready = !r_a_v || b_ready;
    assign o_pop   = i_valid && (!i_entry.emit || a_ready);

    assign n_sum = r_sum - SUM_W'(i_entry.sub_price) + SUM_W'(i_entry.close_price);

    always_comb begin
        total   = {r_b_phi, PRICE_W'(0)} + PROD_W'(r_b_plo);
        shifted = total[PROD_W-1:FRAC_W];
        avg     = (|shifted[SHIFT_W-1:AVG_W]) ? '1 : shifted[AVG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (i_restart) begin
                r_sum <= '0;
            end else if (o_pop) begin
                r_sum <= n_sum;
            end
            if (a_ready) begin
                r_a_v <= o_pop && i_entry.emit;
            end
            if (b_ready) begin
                r_b_v <= r_a_v;
            end
            if (o_adv) begin
                r_o_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_sum <= n_sum;
            r_a_idx <= i_entry.bar_index_res;
            r_a_rev <= i_entry.is_revision;
        end
        if (b_ready) begin
            r_b_plo <= r_a_sum[PRICE_W-1:0] * i_scale_factor;
            r_b_phi <= r_a_sum[SUM_W-1:PRICE_W] * i_scale_factor;
            r_b_idx <= r_a_idx;
            r_b_rev <= r_a_rev;
        end
        if (o_adv) begin
            r_o_avg <= avg;
            r_o_idx <= r_b_idx;
            r_o_rev <= r_b_rev;
        end
    end

    assign o_result.valid         = r_o_v;
    assign o_result.average       = r_o_avg;
    assign o_result.bar_index_res = r_o_idx;
    assign o_result.is_revision   = r_o_rev;

endmodule

@@ tb/sv/smau_average_checker.sv @@
module smau_average_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  smau_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [smau_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [smau_pkg::IDX_W-1:0]    i_bar_index,
    input  logic [smau_pkg::PRICE_W-1:0]  i_close_price,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [smau_pkg::AVG_W-1:0]    i_average,
    input  logic [smau_pkg::IDX_W-1:0]    i_bar_index_res,
    input  logic                          i_is_revision,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count,
    output int                            o_revision_count
);
    import smau_pkg::*;

    typedef struct packed {
        logic [AVG_W-1:0] average;
        logic [IDX_W-1:0] bar_index;
        logic             is_revision;
    } t_avg_beat;

    t_avg_beat          avg_expected_q[$];
    logic [PRICE_W-1:0] close_hist [MAX_WINDOW];
    logic [SUM_W-1:0]   run_sum;
    int unsigned        bars_held;
    int unsigned        head_slot;
    logic [IDX_W-1:0]   head_idx;
    logic               any_bar;
    logic [WLEN_W-1:0]  len_reg;
    logic [SF_W-1:0]    scale_reg;
    int                 fails = 0;
    int                 results = 0;
    int                 revisions = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_result_count = 0;
        o_revision_count = 0;
    end

    function automatic int unsigned window_span(input logic [WLEN_W-1:0] w);
        if (w < LEN_MIN) begin
            return LEN_MIN;
        end
        if (w > MAX_WINDOW) begin
            return MAX_WINDOW;
        end
        return 32'(w);
    endfunction

    task automatic absorb_close(input logic [IDX_W-1:0] idx, input logic [PRICE_W-1:0] price,
                                output bit emit, output t_avg_beat beat);
        int unsigned span;
        int unsigned slot;
        int unsigned oldest;
        logic [63:0] prod;
        logic [63:0] scaled;
        span = window_span(len_reg);
        if (!any_bar || idx > head_idx) begin
            slot = any_bar ? (head_slot + 1) % MAX_WINDOW : head_slot;
            if (bars_held >= span) begin
                oldest = (head_slot + MAX_WINDOW - (span - 1)) % MAX_WINDOW;
                run_sum = run_sum - close_hist[oldest];
                bars_held = span;
            end else begin
                bars_held++;
            end
            close_hist[slot] = price;
            run_sum = run_sum + price;
            head_slot = slot;
            head_idx = idx;
            any_bar = 1'b1;
            beat.is_revision = 1'b0;
        end else begin
            run_sum = run_sum - close_hist[head_slot] + price;
            close_hist[head_slot] = price;
            beat.is_revision = 1'b1;
        end
        prod = 64'(run_sum) * 64'(scale_reg);
        scaled = prod >> FRAC_W;
        beat.average = (scaled > 64'hFFFF_FFFF) ? '1 : scaled[AVG_W-1:0];
        beat.bar_index = head_idx;
        emit = (bars_held >= span);
    endtask

    always @(posedge i_clk) begin : track
        t_avg_beat want;
        t_avg_beat fresh;
        bit        emit;
        if (!i_rst_n) begin
            avg_expected_q.delete();
            run_sum = '0;
            bars_held = 0;
            head_slot = 0;
            head_idx = '0;
            any_bar = 1'b0;
            len_reg = WLEN_RST;
            scale_reg = SF_RST;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (avg_expected_q.size() == 0) begin
                    $display("%0t unexpected average beat: expected none, actual %h/%h/%b",
                             $time, i_average, i_bar_index_res, i_is_revision);
                    fails++;
                end else begin
                    want = avg_expected_q.pop_front();
                    if (i_average !== want.average) begin
                        $display("%0t average mismatch: expected %h, actual %h",
                                 $time, want.average, i_average);
                        fails++;
                    end
                    if (i_bar_index_res !== want.bar_index) begin
                        $display("%0t bar_index_res mismatch: expected %h, actual %h",
                                 $time, want.bar_index, i_bar_index_res);
                        fails++;
                    end
                    if (i_is_revision !== want.is_revision) begin
                        $display("%0t is_revision mismatch: expected %b, actual %b",
                                 $time, want.is_revision, i_is_revision);
                        fails++;
                    end
                    results++;
                    if (want.is_revision) begin
                        revisions++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_LENGTH: begin
                        len_reg = i_cfg_wdata[WLEN_W-1:0];
                        run_sum = '0;
                        bars_held = 0;
                        any_bar = 1'b0;
                    end
                    CFG_SCALE_FACTOR: begin
                        scale_reg = i_cfg_wdata[SF_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                absorb_close(i_bar_index, i_close_price, emit, fresh);
                if (emit) begin
                    avg_expected_q = {avg_expected_q, fresh};
                end
            end
        end
        o_pending <= avg_expected_q.size();
        o_fail_count <= fails;
        o_result_count <= results;
        o_revision_count <= revisions;
    end

endmodule

@@ tb/sv/sliding_window_moving_average_unit_test.sv @@
module sliding_window_moving_average_unit_test;
    import smau_pkg::*;

    localparam int ITEM_TARGET   = 1650;
    localparam int QUIET_TAIL    = 200;
    localparam int SETTLE_CYCLES = 12;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               cfg_we;
    t_cfg_idx           cfg_idx;
    logic [CFG_W-1:0]   cfg_wdata;

    int                 fail_count;
    int                 pending;
    int                 result_count;
    int                 revision_count;

    int                 in_gap_pct = 0;
    int                 out_gap_pct = 0;
    int                 stall_left = 0;
    int                 beats_sent = 0;
    int                 phases_run = 0;
    logic [IDX_W-1:0]   tb_last_idx = '0;
    bit                 tb_fresh = 1'b1;
    logic [PRICE_W-1:0] price_level = '0;

    smau_in_if  item_if ();
    smau_out_if result_if ();

    sliding_window_moving_average_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    smau_average_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (item_if.valid),
        .i_in_ready       (item_if.ready),
        .i_bar_index      (item_if.bar_index),
        .i_close_price    (item_if.close_price),
        .i_out_valid      (result_if.valid),
        .i_out_ready      (result_if.ready),
        .i_average        (result_if.average),
        .i_bar_index_res  (result_if.bar_index_res),
        .i_is_revision    (result_if.is_revision),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_result_count   (result_count),
        .o_revision_count (revision_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            result_if.ready <= 1'b0;
        end else if (out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct) begin
            stall_left <= $urandom_range(1, 19) - 1;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    task automatic push_bar(input logic [IDX_W-1:0] idx, input logic [PRICE_W-1:0] price);
        int gap;
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            gap = $urandom_range(1, 19);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.bar_index <= idx;
        item_if.close_price <= price;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        beats_sent++;
        if (tb_fresh || idx > tb_last_idx) begin
            tb_last_idx = idx;
            tb_fresh = 1'b0;
        end
    endtask

    task automatic drain_and_wait();
        int waited;
        waited = 0;
        item_if.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        drain_and_wait();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW_LENGTH) begin
            tb_fresh = 1'b1;
        end
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (tb_fresh) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return 32'hFFFF_FFFF - $urandom_range(0, 300);
                default: return $urandom;
            endcase
        end
        if (r < 65) begin
            return tb_last_idx + 1;
        end else if (r < 75) begin
            return tb_last_idx + $urandom_range(2, 50);
        end else if (r < 87) begin
            return tb_last_idx;
        end else if (r < 94) begin
            return tb_last_idx - $urandom_range(1, 1000);
        end else if (r < 98) begin
            return tb_last_idx + $urandom;
        end
        return $urandom;
    endfunction

    function automatic logic [PRICE_W-1:0] pick_price();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: return price_level + $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    initial begin
        int unsigned span;
        int unsigned beats_in_phase;
        logic [WLEN_W-1:0] wlen;
        logic [CFG_W-1:0] data;
        logic [SF_W-1:0] scale;
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_WINDOW_LENGTH;
        cfg_wdata <= '0;
        item_if.valid <= 1'b0;
        item_if.bar_index <= '0;
        item_if.close_price <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: window of 20 is not full yet
        push_bar(32'd5, '1);
        push_bar(32'd5, '0);
        push_bar(32'd9, 32'h0001_0000);
        // restart lets a lower index open the first bar
        write_reg(CFG_WINDOW_LENGTH, CFG_W'(2));
        push_bar(32'd7, '1);
        push_bar(32'd7, '1);
        push_bar(32'd8, '1);
        write_reg(CFG_SCALE_FACTOR, '1);
        push_bar(32'd3, '1);
        push_bar('1, '1);
        push_bar('1, '0);
        push_bar(32'd0, 32'h8000_0000);
        write_reg(CFG_SCALE_FACTOR, CFG_W'(1 << FRAC_W));
        push_bar('1, 32'h1234_5678);
        write_reg(CFG_SCALE_FACTOR, '0);
        push_bar(32'd0, '1);
        write_reg(CFG_SCALE_FACTOR, CFG_W'(5592406));
        write_reg(CFG_WINDOW_LENGTH, CFG_W'(3));
        push_bar(32'd100, 32'h0000_0300);
        push_bar(32'd50, 32'h0000_0600);
        push_bar(32'd101, 32'h0000_0900);
        push_bar(32'd102, 32'h0000_0000);
        // length below the minimum acts as two
        write_reg(CFG_WINDOW_LENGTH, CFG_W'(0));
        push_bar(32'd0, 32'd10);
        push_bar(32'd1, 32'd20);

        span = 2;
        while (beats_sent < ITEM_TARGET) begin
            if (beats_sent >= ITEM_TARGET - QUIET_TAIL) begin
                in_gap_pct = 0;
                out_gap_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: in_gap_pct = 0;
                    1: in_gap_pct = 5;
                    default: in_gap_pct = 25;
                endcase
                case ($urandom_range(0, 2))
                    0: out_gap_pct = 0;
                    1: out_gap_pct = 5;
                    default: out_gap_pct = 25;
                endcase
            end
            case (phases_run % 7)
                0: wlen = 7'd2;
                1: wlen = 7'd64;
                2: wlen = 7'd0;
                3: wlen = 7'd127;
                4: wlen = 7'd1;
                default: wlen = WLEN_W'($urandom_range(0, 127));
            endcase
            if (phases_run > 0 && $urandom_range(0, 3) == 0) begin
                wlen = '0;
            end else begin
                span = (wlen < LEN_MIN) ? LEN_MIN : (wlen > MAX_WINDOW) ? MAX_WINDOW : wlen;
            end
            case ($urandom_range(0, 5))
                0: scale = '0;
                1: scale = SF_W'(1 << FRAC_W);
                2: scale = '1;
                3: scale = SF_W'($urandom);
                default: scale = SF_W'((1 << FRAC_W) / span);
            endcase
            write_reg(CFG_SCALE_FACTOR, CFG_W'(scale));
            if (wlen != '0 || (phases_run % 7) == 2) begin
                data = CFG_W'($urandom);
                data[WLEN_W-1:0] = wlen;
                write_reg(CFG_WINDOW_LENGTH, data);
            end
            price_level = $urandom;
            beats_in_phase = 2 * span + $urandom_range(10, 60);
            repeat (beats_in_phase) begin
                push_bar(pick_index(), pick_price());
            end
            phases_run++;
        end

        drain_and_wait();
        $display("run covered %0d input beats in %0d random phases after the directed part",
                 beats_sent, phases_run);
        $display("checked %0d averages, %0d of them after a revision",
                 result_count, revision_count);
        if (pending != 0) begin
            $display("%0t %0d averages never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
